// ===== design/fba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// shared constants and types of the frame bitmap allocator
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int BITMAP_WORDS = 128;
    localparam int WORD_AW      = $clog2(BITMAP_WORDS);
    localparam int FRAME_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int WORDS_W      = WORD_AW + 1;
    localparam int STATUS_W     = 3;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY_MAPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TAKEN_TWICE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED          = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREE_UNMAPPED  = 3'd5;

    // bitmap write port, one word per cycle
    typedef struct packed {
        logic                 en;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] data;
    } t_wr_port;

endpackage

// ===== design/fba_bitmap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_bitmap
// frame bitmap memory, one write and one registered read port; a word never
// written since reset reads as all free
// ----------------------------------------------------------------------------
module fba_bitmap (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [fba_pkg::WORD_AW-1:0]     i_rd_addr,
    input  fba_pkg::t_wr_port               i_wr,
    output logic [fba_pkg::WORD_BITS-1:0]   o_rd_data
);

    logic [fba_pkg::WORD_BITS-1:0]    r_mem [fba_pkg::BITMAP_WORDS];
    logic [fba_pkg::BITMAP_WORDS-1:0] r_valid;
    logic [fba_pkg::WORD_BITS-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fba_first_zero.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_first_zero
// finds the lowest clear bit of one bitmap word
// ----------------------------------------------------------------------------
module fba_first_zero (
    input  logic [fba_pkg::WORD_BITS-1:0]  i_word,
    output logic                           o_found,
    output logic [fba_pkg::BIT_IDX_W-1:0]  o_pos
);

    always_comb begin
        o_found = ~&i_word;
        o_pos   = '0;
        // walk down so the lowest clear bit wins
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_pos = fba_pkg::BIT_IDX_W'(i);
            end
        end
    end

endmodule

// ===== design/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// first-fit physical frame allocator over a one-bit-per-frame bitmap
// ----------------------------------------------------------------------------
// One request beat is worked on at a time; o_s_axis_tready is high only while
// the sequencer is idle. A free, or an allocate of a named frame, goes through
// accept, read-modify-write of one bitmap word and hand-off to the output
// register. Requests that touch no memory (already mapped, free of frame
// zero, empty scan range) go through accept and hand-off only. A first-fit
// allocate reads bitmap words, one word per cycle through the single bitmap
// read port, until a free bit is found or the range ends, then hands off.
// The finished result waits in the output register, so the next request may
// be taken while the previous result is still not taken downstream. The
// bitmap comes out of reset all free at once (per-word valid bits), with no
// clearing pass. frame_count must be written through i_cfg_we / i_cfg_wdata
// only while idle; the block does not enforce this. The scan covers the whole
// 32-bit words below frame_count, capped at the bitmap size.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // current_frame[11:0], pick_any[12],
                                         // requested_frame[24:13], kernel_page[25],
                                         // is_writable[26], zero fill
    input  logic        i_s_axis_tuser,  // opcode[0]
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // frame[11:0], present[12], writable[13],
                                         // user_mode[14], zero fill
    output logic [2:0]  o_m_axis_tuser,  // status[2:0]
    // configuration: frame_count
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata
);

    localparam logic [fba_pkg::WORDS_W-1:0] WORDS_MAX =
        fba_pkg::WORDS_W'(fba_pkg::BITMAP_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [fba_pkg::STATUS_W-1:0] status;
        logic [fba_pkg::FRAME_W-1:0]  frame;
        logic                         present;
        logic                         writable;
        logic                         user_mode;
    } t_result;

    // request fields as they sit on the bus
    logic                         in_op;
    logic [fba_pkg::FRAME_W-1:0]  in_cur;
    logic                         in_any;
    logic [fba_pkg::FRAME_W-1:0]  in_req;
    logic                         in_kernel;
    logic                         in_writable;

    assign in_op       = i_s_axis_tuser;
    assign in_cur      = i_s_axis_tdata[11:0];
    assign in_any      = i_s_axis_tdata[12];
    assign in_req      = i_s_axis_tdata[24:13];
    assign in_kernel   = i_s_axis_tdata[25];
    assign in_writable = i_s_axis_tdata[26];

    t_state                          r_state, n_state;
    logic [fba_pkg::WORDS_W-1:0]     r_words;       // scan range in words
    logic [fba_pkg::FRAME_W-1:0]     r_frame, n_frame;
    logic                            r_free, n_free;
    logic                            r_wr, n_wr;
    logic                            r_user, n_user;
    logic [fba_pkg::WORD_AW-1:0]     r_idx, n_idx;
    t_result                         r_res, n_res;
    logic                            r_m_valid;
    t_result                         r_m_res;

    logic                            s_accept;
    logic                            out_free;
    logic                            rd_en;
    logic [fba_pkg::WORD_AW-1:0]     rd_addr;
    logic [fba_pkg::WORD_BITS-1:0]   rd_data;
    fba_pkg::t_wr_port               wr;
    logic                            zero_found;
    logic [fba_pkg::BIT_IDX_W-1:0]   zero_pos;
    logic [fba_pkg::WORD_BITS-1:0]   rmw_mask;
    logic [fba_pkg::WORD_BITS-1:0]   scan_mask;
    logic [fba_pkg::WORDS_W-1:0]     idx_next;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    fba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    // search unit of the first-fit scan: lowest free bit of the word just read
    fba_first_zero u_first_zero (
        .i_word  (rd_data),
        .o_found (zero_found),
        .o_pos   (zero_pos)
    );

    assign rmw_mask  = fba_pkg::WORD_BITS'(1) << r_frame[fba_pkg::BIT_IDX_W-1:0];
    assign scan_mask = fba_pkg::WORD_BITS'(1) << zero_pos;
    assign idx_next  = {1'b0, r_idx} + fba_pkg::WORDS_W'(1);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_frame = r_frame;
        n_free  = r_free;
        n_wr    = r_wr;
        n_user  = r_user;
        n_idx   = r_idx;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr      = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_free = (in_op != fba_pkg::OP_ALLOC);
                    n_wr   = in_writable;
                    n_user = ~in_kernel;
                    n_res  = '0;
                    if (in_op != fba_pkg::OP_ALLOC) begin
                        if (in_cur == '0) begin
                            n_res.status = fba_pkg::ST_FREE_UNMAPPED;
                            n_state      = S_HOLD;
                        end else begin
                            n_frame = in_cur;
                            rd_en   = 1'b1;
                            rd_addr = in_cur[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
                            n_state = S_RMW;
                        end
                    end else if (in_cur != '0) begin
                        // page already holds a frame: report it, touch nothing
                        n_res.status  = fba_pkg::ST_ALREADY_MAPPED;
                        n_res.frame   = in_cur;
                        n_res.present = 1'b1;
                        n_state       = S_HOLD;
                    end else if (in_any) begin
                        if (r_words == '0) begin
                            n_res.status = fba_pkg::ST_NO_FREE;
                            n_state      = S_HOLD;
                        end else begin
                            n_idx   = '0;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_frame = in_req;
                        rd_en   = 1'b1;
                        rd_addr = in_req[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                wr.en   = 1'b1;
                wr.addr = r_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
                n_res   = '0;
                if (r_free) begin
                    wr.data      = rd_data & ~rmw_mask;
                    n_res.status = fba_pkg::ST_FREED;
                end else begin
                    wr.data        = rd_data | rmw_mask;
                    n_res.status   = rd_data[r_frame[fba_pkg::BIT_IDX_W-1:0]] ?
                                     fba_pkg::ST_TAKEN_TWICE : fba_pkg::ST_ALLOCATED;
                    n_res.frame    = r_frame;
                    n_res.present  = 1'b1;
                    n_res.writable = r_wr;
                    n_res.user_mode = r_user;
                end
                n_state = S_HOLD;
            end
            S_SCAN: begin
                // rd_data holds word r_idx
                n_res = '0;
                if (zero_found) begin
                    wr.en           = 1'b1;
                    wr.addr         = r_idx;
                    wr.data         = rd_data | scan_mask;
                    n_res.status    = fba_pkg::ST_ALLOCATED;
                    n_res.frame     = {r_idx, zero_pos};
                    n_res.present   = 1'b1;
                    n_res.writable  = r_wr;
                    n_res.user_mode = r_user;
                    n_state         = S_HOLD;
                end else if (idx_next == r_words) begin
                    n_res.status = fba_pkg::ST_NO_FREE;
                    n_state      = S_HOLD;
                end else begin
                    n_idx   = idx_next[fba_pkg::WORD_AW-1:0];
                    rd_en   = 1'b1;
                    rd_addr = idx_next[fba_pkg::WORD_AW-1:0];
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_words   <= WORDS_MAX;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                // whole words below frame_count, capped at the bitmap size
                r_words <= i_cfg_wdata[fba_pkg::COUNT_W-1] ? WORDS_MAX :
                           fba_pkg::WORDS_W'(i_cfg_wdata[fba_pkg::COUNT_W-2:
                                                         fba_pkg::BIT_IDX_W]);
            end
            if (r_state == S_HOLD && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        r_frame <= n_frame;
        r_free  <= n_free;
        r_wr    <= n_wr;
        r_user  <= n_user;
        r_idx   <= n_idx;
        r_res   <= n_res;
        if (r_state == S_HOLD && out_free) begin
            r_m_res <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_res.status;
    assign o_m_axis_tdata  = {1'b0, r_m_res.user_mode, r_m_res.writable,
                              r_m_res.present, r_m_res.frame};

    // bitmap is only written from the read-modify-write and scan steps
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_RMW || r_state == S_SCAN))
        else $error("bitmap write outside rmw or scan");

    // scan never looks past the configured range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < r_words))
        else $error("scan index beyond frame range");

    // a first-fit allocate with an empty range finishes at once
    a_empty_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_op == fba_pkg::OP_ALLOC && in_cur == '0 && in_any &&
         r_words == '0)
        |=> (r_state == S_HOLD && r_res.status == fba_pkg::ST_NO_FREE))
        else $error("empty scan range did not report no free frame");

    // results that map nothing carry an all-zero page entry
    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == fba_pkg::ST_NO_FREE ||
                             o_m_axis_tuser == fba_pkg::ST_FREED ||
                             o_m_axis_tuser == fba_pkg::ST_FREE_UNMAPPED))
        |-> (o_m_axis_tdata == '0))
        else $error("non-mapping result with page entry bits set");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator testbench
// streams allocate and free requests into the allocator, including the corner
// cases: frame zero, taken twice, already mapped, no free frame, and free of
// unmapped. Every result beat is checked field by field against an in-bench
// bitmap model or a hand-pinned entry. frame_count is swept between phases
// while idle, with random idling and a long back-pressure result hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_PHASES      = 6;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 140;  // longest first-fit scan plus hand-off

    typedef struct packed {
        logic                        op;
        logic [fba_pkg::FRAME_W-1:0] cur;
        logic                        pick_any;
        logic [fba_pkg::FRAME_W-1:0] req;
        logic                        kern;
        logic                        wr;
    } t_req;

    typedef struct packed {
        logic [fba_pkg::STATUS_W-1:0] status;
        logic [fba_pkg::FRAME_W-1:0]  frame;
        logic                         present;
        logic                         writable;
        logic                         user_mode;
    } t_entry;

    typedef struct {
        bit                          is_cfg;
        logic [fba_pkg::COUNT_W-1:0] cfg_val;
        t_req                        req;
        bit                          typed;
        t_entry                      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;

    // bitmap model and frame_count copy
    logic [fba_pkg::WORD_BITS-1:0] frame_map [fba_pkg::BITMAP_WORDS];
    logic [fba_pkg::COUNT_W-1:0]   managed_frames;

    t_entry entries_due[$];
    t_row   directed_rows[$];
    int     error_count;
    int     src_idle_pct;
    int     sink_idle_pct;
    bit     hold_off_request;

    int unsigned phase_frames[NUM_PHASES] = '{4096, 64, 100, 4095, 0, 4096};
    int unsigned phase_items[NUM_PHASES]  = '{250, 250, 250, 200, 100, 200};

    frame_bitmap_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // expected page entry for one request; updates the bitmap model
    task automatic compute_entry(input t_req r, output t_entry e);
        logic [fba_pkg::FRAME_W-1:0]   f;
        logic [fba_pkg::WORD_AW-1:0]   w_idx;
        logic [fba_pkg::BIT_IDX_W-1:0] b_idx;
        int unsigned                   words;
        bit                            found;
        e = '0;
        if (r.op == fba_pkg::OP_FREE) begin
            if (r.cur == '0) begin
                e.status = fba_pkg::ST_FREE_UNMAPPED;
            end else begin
                {w_idx, b_idx} = r.cur;
                frame_map[w_idx][b_idx] = 1'b0;
                e.status = fba_pkg::ST_FREED;
            end
        end else if (r.cur != '0) begin
            // page already holds a frame, nothing changes
            e.status  = fba_pkg::ST_ALREADY_MAPPED;
            e.frame   = r.cur;
            e.present = 1'b1;
        end else begin
            found = 1'b1;
            f     = r.req;
            if (r.pick_any) begin
                // first fit over whole words below frame_count
                found = 1'b0;
                words = managed_frames / fba_pkg::WORD_BITS;
                if (words > fba_pkg::BITMAP_WORDS) words = fba_pkg::BITMAP_WORDS;
                for (int i = 0; i < words; i++) begin
                    if (!found && frame_map[i] != '1) begin
                        for (int j = 0; j < fba_pkg::WORD_BITS; j++) begin
                            if (!found && !frame_map[i][j]) begin
                                found = 1'b1;
                                f     = fba_pkg::FRAME_W'(i * fba_pkg::WORD_BITS + j);
                            end
                        end
                    end
                end
            end
            if (!found) begin
                e.status = fba_pkg::ST_NO_FREE;
            end else begin
                {w_idx, b_idx} = f;
                e.status = frame_map[w_idx][b_idx]
                         ? fba_pkg::ST_TAKEN_TWICE : fba_pkg::ST_ALLOCATED;
                frame_map[w_idx][b_idx] = 1'b1;
                e.frame     = f;
                e.present   = 1'b1;
                e.writable  = r.wr;
                e.user_mode = ~r.kern;
            end
        end
    endtask

    function automatic t_row row_beat(input logic op, input int unsigned cur,
                                      input int unsigned any, input int unsigned req,
                                      input int unsigned kern, input int unsigned wr);
        t_row r;
        r          = '{default: '0};
        r.req.op   = op;
        r.req.cur  = fba_pkg::FRAME_W'(cur);
        r.req.pick_any = 1'(any);
        r.req.req  = fba_pkg::FRAME_W'(req);
        r.req.kern = 1'(kern);
        r.req.wr   = 1'(wr);
        return r;
    endfunction

    // pins the expected entry of a row where it is obvious by hand
    function automatic t_row with_entry(input t_row r,
                                        input logic [fba_pkg::STATUS_W-1:0] st,
                                        input int unsigned frame, input int unsigned p,
                                        input int unsigned w, input int unsigned u);
        t_row t;
        t                = r;
        t.typed          = 1'b1;
        t.want.status    = st;
        t.want.frame     = fba_pkg::FRAME_W'(frame);
        t.want.present   = 1'(p);
        t.want.writable  = 1'(w);
        t.want.user_mode = 1'(u);
        return t;
    endfunction

    function automatic t_row row_cfg(input int unsigned v);
        t_row r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_val = fba_pkg::COUNT_W'(v);
        return r;
    endfunction

    // mostly well-formed allocate/free traffic inside the managed window
    function automatic t_req random_request(input int unsigned win);
        t_req        r;
        int unsigned pick;
        pick       = $urandom_range(99);
        r.op       = fba_pkg::OP_ALLOC;
        r.cur      = '0;
        r.pick_any = 1'($urandom_range(1));
        r.req      = fba_pkg::FRAME_W'($urandom);
        r.kern     = 1'($urandom_range(1));
        r.wr       = 1'($urandom_range(1));
        if (pick < 8) begin
            // noise: any field combination
            r.op  = 1'($urandom_range(1));
            r.cur = fba_pkg::FRAME_W'($urandom);
        end else if (pick < 62) begin
            if ($urandom_range(9) == 0) r.cur = fba_pkg::FRAME_W'($urandom_range(4095, 1));
            r.pick_any = ($urandom_range(9) < 6);
            if ($urandom_range(9) != 0) r.req = fba_pkg::FRAME_W'($urandom_range(win - 1));
        end else begin
            r.op = fba_pkg::OP_FREE;
            if ($urandom_range(19) != 0) r.cur = fba_pkg::FRAME_W'($urandom_range(win - 1));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r, input bit typed, input t_entry want);
        t_entry e;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, r.wr, r.kern, r.req, r.pick_any, r.cur};
        i_s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        compute_entry(r, e);
        entries_due.push_back(typed ? want : e);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_all_entries();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (entries_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [fba_pkg::COUNT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        managed_frames = v;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random readiness, or a long hold-off on request
    initial begin : result_sink
        i_m_axis_tready <= 1'b0;
        forever begin
            if (hold_off_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_request = 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge i_clk);
            end
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_entry want;
        t_entry got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status    = o_m_axis_tuser;
            got.frame     = o_m_axis_tdata[fba_pkg::FRAME_W-1:0];
            got.present   = o_m_axis_tdata[12];
            got.writable  = o_m_axis_tdata[13];
            got.user_mode = o_m_axis_tdata[14];
            if (entries_due.size() == 0) begin
                $error("result beat with nothing expected: status %0d frame %0d",
                       got.status, got.frame);
                error_count++;
            end else begin
                want = entries_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.frame !== want.frame) begin
                    $error("frame: expected %0d, got %0d", want.frame, got.frame);
                    error_count++;
                end
                if (got.present !== want.present) begin
                    $error("present: expected %0d, got %0d", want.present, got.present);
                    error_count++;
                end
                if (got.writable !== want.writable) begin
                    $error("writable: expected %0d, got %0d", want.writable, got.writable);
                    error_count++;
                end
                if (got.user_mode !== want.user_mode) begin
                    $error("user_mode: expected %0d, got %0d",
                           want.user_mode, got.user_mode);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned win;
        error_count      = 0;
        hold_off_request = 1'b0;
        src_idle_pct     = 14;
        sink_idle_pct    = 87;
        managed_frames   = fba_pkg::COUNT_W'(4096);
        foreach (frame_map[i]) frame_map[i] = '0;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;

        // directed rows: op, current, pick_any, requested, kernel, writable
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 0, 1),
            fba_pkg::ST_ALLOCATED, 0, 1, 1, 1));       // frame zero
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 1, 4095, 1, 0),
            fba_pkg::ST_ALLOCATED, 1, 1, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 0, 4095, 1, 1),
            fba_pkg::ST_ALLOCATED, 4095, 1, 1, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 0, 4095, 0, 0),
            fba_pkg::ST_TAKEN_TWICE, 4095, 1, 0, 1));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 4095, 1, 0, 0, 1),
            fba_pkg::ST_ALREADY_MAPPED, 4095, 1, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 0, 0, 0, 0, 0),
            fba_pkg::ST_FREE_UNMAPPED, 0, 0, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 4095, 0, 0, 0, 0),
            fba_pkg::ST_FREED, 0, 0, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 0, 4095, 0, 1),
            fba_pkg::ST_ALLOCATED, 4095, 1, 1, 1));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 1, 0, 0, 0, 0),
            fba_pkg::ST_FREED, 0, 0, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 0, 0),
            fba_pkg::ST_ALLOCATED, 1, 1, 0, 1));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 0, 0, 1, 1),
            fba_pkg::ST_TAKEN_TWICE, 0, 1, 1, 0));
        directed_rows.push_back(row_beat(fba_pkg::OP_ALLOC, 0, 0, 'hAAA, 0, 1));
        directed_rows.push_back(row_beat(fba_pkg::OP_ALLOC, 0, 0, 'h555, 1, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 'hAAA, 0, 0, 1, 1),
            fba_pkg::ST_ALREADY_MAPPED, 'hAAA, 1, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 'h555, 1, 'hFFF, 0, 0),
            fba_pkg::ST_ALREADY_MAPPED, 'h555, 1, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 'hAAA, 0, 0, 0, 0),
            fba_pkg::ST_FREED, 0, 0, 0, 0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 'h555, 1, 'h555, 1, 1),
            fba_pkg::ST_FREED, 0, 0, 0, 0));
        directed_rows.push_back(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 1, 1));
        // empty scan range, then a partial word that is never scanned
        directed_rows.push_back(row_cfg(0));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 0, 1),
            fba_pkg::ST_NO_FREE, 0, 0, 0, 0));
        directed_rows.push_back(row_cfg(31));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 0, 1),
            fba_pkg::ST_NO_FREE, 0, 0, 0, 0));
        // a named frame is not checked against frame_count
        directed_rows.push_back(row_beat(fba_pkg::OP_ALLOC, 0, 0, 4095, 0, 1));
        directed_rows.push_back(row_cfg(32));
        directed_rows.push_back(row_beat(fba_pkg::OP_ALLOC, 0, 1, 0, 0, 1));
        directed_rows.push_back(with_entry(row_beat(fba_pkg::OP_FREE, 4095, 1, 'hFFF, 1, 1),
            fba_pkg::ST_FREED, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_all_entries();
                write_frame_count(directed_rows[k].cfg_val);
            end else begin
                send_request(directed_rows[k].req, directed_rows[k].typed,
                             directed_rows[k].want);
            end
        end

        // random phases, each with its own frame_count and idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_all_entries();
            write_frame_count(fba_pkg::COUNT_W'(phase_frames[p]));
            case (p % 3)
                0: begin
                    src_idle_pct  = 14;
                    sink_idle_pct = 87;
                end
                1: begin
                    src_idle_pct  = 87;
                    sink_idle_pct = 14;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            win = (phase_frames[p] < fba_pkg::WORD_BITS) ? fba_pkg::WORD_BITS
                                                         : phase_frames[p];
            // long result-side hold-off while requests keep coming
            if (p == 2) hold_off_request = 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                // sender pause until everything is back
                if (n == phase_items[p] / 2) wait_all_entries();
                send_request(random_request(win), 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (entries_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && entries_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/fba_pkg.sv
design/fba_bitmap.sv
design/fba_first_zero.sv
design/frame_bitmap_allocator.sv
dv/testbench.sv
